// File: sv/block_cache_lru_tags_top_macros.svh
// Assertion macros shared by the block cache tag manager.
// All checks are sampled on clk_i and are disabled while rst_ni is low.
`ifndef BLOCK_CACHE_LRU_TAGS_TOP_MACROS_SVH
`define BLOCK_CACHE_LRU_TAGS_TOP_MACROS_SVH

// Same-cycle implication.
`define BCLT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BCLT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bclt_pkg.sv
// ----------------------------------------------------------------------------
// bclt_pkg
// Types and constants shared by the block cache tag manager modules.
// ----------------------------------------------------------------------------
package bclt_pkg;

  localparam int DEFAULT_ENTRIES = 512;
  localparam int TAG_W           = 32;
  localparam int AGE_W           = 32;
  localparam int ENTRY_W         = TAG_W + AGE_W;
  localparam int SLOT_W          = 9;
  localparam int ACT_W           = 2;

  localparam logic [ACT_W-1:0] ACT_IGNORED    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_HIT        = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ_MISS  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_WRITE_MISS = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_WRITE,
    ST_PUSH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // capture the request and restart the scan
    logic scan_rd;   // read the entry at the scan index and advance
    logic clear_wr;  // write an empty entry at the scan index and advance
    logic upd_wr;    // retag or refresh the chosen slot, advance the clock
    logic out_load;  // load the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_last;  // scan index is at the last slot
    logic in_zero;   // offered block number is zero
    logic out_free;  // output register can take a result this cycle
  } sts_t;

endpackage

// File: sv/bclt_ram.sv
// ----------------------------------------------------------------------------
// bclt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bclt_ram
  import bclt_pkg::*;
#(
  parameter int  WIDTH  = ENTRY_W,
  parameter int  DEPTH  = DEFAULT_ENTRIES,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/bclt_ctrl.sv
// ----------------------------------------------------------------------------
// bclt_ctrl
// Sequencer for the tag manager: clearing pass, tag scan, update and result.
// ----------------------------------------------------------------------------
`include "block_cache_lru_tags_top_macros.svh"

module bclt_ctrl
  import bclt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.idx_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          // A zero block number needs no lookup.
          state_d = sts_i.in_zero ? ST_PUSH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.idx_last) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        // The last entry read is compared in this cycle.
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.upd_wr = 1'b1;
        state_d      = ST_PUSH;
      end
      ST_PUSH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  `BCLT_ASSERT_NXT(a_scan_runs, (state_q == ST_SCAN) && !sts_i.idx_last, state_q == ST_SCAN, "scan left before the last slot")
  `BCLT_ASSERT_NXT(a_write_once, cmd_o.upd_wr, !cmd_o.upd_wr, "slot updated twice for one transaction")
  `BCLT_ASSERT_NXT(a_clear_done, (state_q == ST_CLEAR) && sts_i.idx_last, in_ready_o, "not ready after the clearing pass")

endmodule

// File: sv/bclt_dp.sv
// ----------------------------------------------------------------------------
// bclt_dp
// Datapath: tag and age memory, scan index, hit and victim tracking, access
// clock and output register.
// ----------------------------------------------------------------------------
`include "block_cache_lru_tags_top_macros.svh"

module bclt_dp
  import bclt_pkg::*;
#(
  parameter int ENTRIES = DEFAULT_ENTRIES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic               kind_i,
  input  logic [TAG_W-1:0]   block_number_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ACT_W-1:0]   action_o,
  output logic [SLOT_W-1:0]  slot_o,
  output logic [TAG_W-1:0]   evicted_block_o
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

  // Request held for the whole transaction.
  logic             kind_q;
  logic [TAG_W-1:0] blk_q;

  logic [IDX_W-1:0] idx_q, idx_d;
  logic             cmp_vld_q;
  logic [IDX_W-1:0] cmp_idx_q;

  logic             hit_q, hit_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic [IDX_W-1:0] vic_idx_q, vic_idx_d;
  logic [AGE_W-1:0] vic_age_q, vic_age_d;
  logic [TAG_W-1:0] vic_tag_q, vic_tag_d;

  logic [AGE_W-1:0] clock_q;

  logic              out_valid_q;
  logic [ACT_W-1:0]  action_q, action_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [TAG_W-1:0]  evicted_q, evicted_d;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [TAG_W-1:0]   rd_tag;
  logic [AGE_W-1:0]   rd_age;

  bclt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign rd_tag = ram_rdata[ENTRY_W-1:AGE_W];
  assign rd_age = ram_rdata[AGE_W-1:0];

  assign ram_we    = cmd_i.clear_wr | cmd_i.upd_wr;
  assign ram_waddr = cmd_i.clear_wr ? idx_q : (hit_q ? hit_idx_q : vic_idx_q);
  assign ram_wdata = cmd_i.clear_wr ? '0 : {blk_q, clock_q};

  // Scan index, shared by the clearing pass and the lookup.
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.start) begin
      idx_d = '0;
    end else if (cmd_i.scan_rd || cmd_i.clear_wr) begin
      idx_d = (idx_q == IDX_LAST) ? '0 : idx_q + IDX_W'(1);
    end
  end

  // First matching tag wins; the victim is the oldest entry, lowest index
  // on a tie, seeded from slot 0.
  always_comb begin
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    vic_idx_d = vic_idx_q;
    vic_age_d = vic_age_q;
    vic_tag_d = vic_tag_q;
    if (cmd_i.start) begin
      hit_d = 1'b0;
    end else if (cmp_vld_q) begin
      if (!hit_q && (rd_tag == blk_q)) begin
        hit_d     = 1'b1;
        hit_idx_d = cmp_idx_q;
      end
      if ((cmp_idx_q == '0) || (rd_age < vic_age_q)) begin
        vic_idx_d = cmp_idx_q;
        vic_age_d = rd_age;
        vic_tag_d = rd_tag;
      end
    end
  end

  always_comb begin
    if (blk_q == '0) begin
      action_d  = ACT_IGNORED;
      slot_d    = '0;
      evicted_d = '0;
    end else if (hit_q) begin
      action_d  = ACT_HIT;
      slot_d    = SLOT_W'(hit_idx_q);
      evicted_d = '0;
    end else begin
      action_d  = kind_q ? ACT_WRITE_MISS : ACT_READ_MISS;
      slot_d    = SLOT_W'(vic_idx_q);
      evicted_d = vic_tag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      clock_q     <= AGE_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      idx_q     <= idx_d;
      cmp_vld_q <= cmd_i.scan_rd;
      hit_q     <= hit_d;
      if (cmd_i.upd_wr) begin
        clock_q <= clock_q + AGE_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      kind_q <= kind_i;
      blk_q  <= block_number_i;
    end
    cmp_idx_q <= idx_q;
    hit_idx_q <= hit_idx_d;
    vic_idx_q <= vic_idx_d;
    vic_age_q <= vic_age_d;
    vic_tag_q <= vic_tag_d;
    if (cmd_i.out_load) begin
      action_q  <= action_d;
      slot_q    <= slot_d;
      evicted_q <= evicted_d;
    end
  end

  assign sts_o.idx_last = (idx_q == IDX_LAST);
  assign sts_o.in_zero  = (block_number_i == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign action_o        = action_q;
  assign slot_o          = slot_q;
  assign evicted_block_o = evicted_q;

  `BCLT_ASSERT_NXT(a_clock_step, cmd_i.upd_wr, clock_q == ($past(clock_q) + AGE_W'(1)), "access clock did not advance by one")

endmodule

// File: sv/block_cache_lru_tags_top.sv
// Tag and LRU replacement manager for a fully associative disk block cache.
// Input channel (in_valid_i / in_ready_o) carries one request: kind_i
// (0 read, 1 write) and block_number_i. Output channel (out_valid_o /
// out_ready_i) returns one result per request: action_o, slot_o and
// evicted_block_o. A block number of zero is answered as ignored.
// Each request scans every slot of one tag and age memory, one entry per
// cycle through its single read port; the last entry read is then compared,
// the chosen slot is written, and the result is loaded into the output
// register once it is free. An ignored request skips the scan and the
// update and goes straight to loading its result.
// One request is in work at a time.
// After reset the block runs a clearing pass that writes every slot empty;
// in_ready_o stays low until it ends.
// A finished result sits in the output register; the block accepts the next
// request while it waits, and holds that request's result until the register
// is free, so a stalled receiver loses nothing.
// ----------------------------------------------------------------------------
// block_cache_lru_tags_top
// Top level: joins the sequencer and the datapath.
// ----------------------------------------------------------------------------
module block_cache_lru_tags_top
  import bclt_pkg::*;
#(
  parameter int ENTRIES = DEFAULT_ENTRIES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [TAG_W-1:0]  block_number_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ACT_W-1:0]  action_o,
  output logic [SLOT_W-1:0] slot_o,
  output logic [TAG_W-1:0]  evicted_block_o
);

  cmd_t cmd;
  sts_t sts;

  bclt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bclt_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .kind_i          (kind_i),
    .block_number_i  (block_number_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .action_o        (action_o),
    .slot_o          (slot_o),
    .evicted_block_o (evicted_block_o)
  );

endmodule
